[src/ehmf_pkg.sv]
package ehmf_pkg;

   localparam int FILTER_ENTRIES_DEFAULT = 8;
   localparam int MAX_FRAME_DEFAULT      = 65535;
   localparam int LIST_COUNT             = 7;

   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [2:0] LIST_SRC_IP   = 3'd0;
   localparam logic [2:0] LIST_DST_IP   = 3'd1;
   localparam logic [2:0] LIST_SRC_PORT = 3'd2;
   localparam logic [2:0] LIST_DST_PORT = 3'd3;
   localparam logic [2:0] LIST_SRC_MAC  = 3'd4;
   localparam logic [2:0] LIST_DST_MAC  = 3'd5;
   localparam logic [2:0] LIST_PROTOCOL = 3'd6;

   localparam logic [15:0] DST_MAC_END   = 16'd6;
   localparam logic [15:0] SRC_MAC_END   = 16'd12;
   localparam logic [15:0] PROTOCOL_POS  = 16'd23;
   localparam logic [15:0] SRC_IP_START  = 16'd26;
   localparam logic [15:0] DST_IP_START  = 16'd30;
   localparam logic [15:0] SRC_PORT_START = 16'd34;
   localparam logic [15:0] DST_PORT_START = 16'd36;
   localparam logic [15:0] HEADER_END    = 16'd38;
   localparam logic [15:0] SHORT_LIMIT   = 16'd42;

   typedef enum logic [1:0] {
      STATUS_ACCEPT = 2'd0,
      STATUS_REJECT = 2'd1,
      STATUS_SHORT  = 2'd2
   } status_type;

   typedef struct packed {
      logic        op;
      logic [7:0]  data_byte;
      logic        last;
      logic [2:0]  list_sel;
      logic [2:0]  entry_index;
      logic [47:0] entry_value;
      logic        entry_valid;
   } req_word_type;

   typedef struct packed {
      logic        accept;
      status_type  status;
      logic [15:0] frame_length;
   } rsp_word_type;

endpackage

[src/ethernet_header_match_filter.sv]
// Ethernet/IPv4 header match filter.
// The request channel carries one word per cycle unless stalled: a frame byte
// in wire order, with last marking the final byte, or a write into one slot of
// the seven match lists (source and destination MAC, IP and port, and protocol).
// Header fields are captured at fixed offsets, assuming no VLAN tag and no IP
// options. A list with no valid slot passes everything.
// On the last byte one response word gives the verdict and the frame length,
// which saturates at MAX_FRAME. Frames of 42 bytes or fewer are reported short.
// Filter writes and non-final bytes produce no response.
// Throughput is one word per cycle unless a final byte stalls. Every word is
// registered on acceptance and processed from the input register, where the
// list compares run in parallel against the captured fields; the final byte's
// verdict is then registered in the response register, which drives rsp_valid.
// When the receiver stalls, the response register holds its word, one more
// request word is taken into the input register, and further frame bytes and
// writes continue to flow until a final byte finds the response still held.
// Synchronous reset clears the byte count, empties every list and drops both
// valid flags; list contents are undefined until written.
module ethernet_header_match_filter #(
   parameter int FILTER_ENTRIES = ehmf_pkg::FILTER_ENTRIES_DEFAULT,
   parameter int MAX_FRAME      = ehmf_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ehmf_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ehmf_pkg::rsp_word_type rsp_word
);

   localparam int IW = (FILTER_ENTRIES > 1) ? $clog2(FILTER_ENTRIES) : 1;

   logic                   a_valid_ff;
   ehmf_pkg::req_word_type a_word_ff;
   logic                   rsp_valid_ff;
   ehmf_pkg::rsp_word_type rsp_word_ff;
   ehmf_pkg::rsp_word_type rsp_word_in;

   logic [15:0] count_ff;
   logic [15:0] count_in;
   logic [47:0] dst_mac_ff, dst_mac_in;
   logic [47:0] src_mac_ff, src_mac_in;
   logic [7:0]  protocol_ff, protocol_in;
   logic [31:0] src_ip_ff, src_ip_in;
   logic [31:0] dst_ip_ff, dst_ip_in;
   logic [15:0] src_port_ff, src_port_in;
   logic [15:0] dst_port_ff, dst_port_in;

   logic [31:0] src_ip_table_ff   [FILTER_ENTRIES];
   logic [31:0] dst_ip_table_ff   [FILTER_ENTRIES];
   logic [15:0] src_port_table_ff [FILTER_ENTRIES];
   logic [15:0] dst_port_table_ff [FILTER_ENTRIES];
   logic [47:0] src_mac_table_ff  [FILTER_ENTRIES];
   logic [47:0] dst_mac_table_ff  [FILTER_ENTRIES];
   logic [7:0]  protocol_table_ff [FILTER_ENTRIES];
   logic [FILTER_ENTRIES-1:0] slot_valid_ff [ehmf_pkg::LIST_COUNT];

   logic [FILTER_ENTRIES-1:0] hit_src_ip, hit_dst_ip, hit_src_port, hit_dst_port;
   logic [FILTER_ENTRIES-1:0] hit_src_mac, hit_dst_mac, hit_protocol;
   logic [ehmf_pkg::LIST_COUNT-1:0] list_pass;

   logic           out_free;
   logic           is_frame;
   logic           is_final;
   logic           a_fire;
   logic           rsp_load;
   logic           wr_en;
   logic [IW-1:0]  wr_idx;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_frame = a_word_ff.op == ehmf_pkg::OP_FRAME;
   assign is_final = is_frame && a_word_ff.last;
   assign a_fire   = a_valid_ff && (!is_final || out_free);
   assign rsp_load = a_fire && is_final;
   assign req_stall = a_valid_ff && !a_fire;

   assign wr_en  = a_fire && (a_word_ff.op == ehmf_pkg::OP_WRITE)
                   && (a_word_ff.list_sel < 3'(ehmf_pkg::LIST_COUNT))
                   && (int'(a_word_ff.entry_index) < FILTER_ENTRIES);
   assign wr_idx = IW'(a_word_ff.entry_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         a_valid_ff <= 1'b1;
      end else if (a_fire) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         a_word_ff <= req_word;
      end
   end

   // Header capture: each field shifts in big-endian over its byte range.
   always_comb begin
      count_in    = count_ff;
      dst_mac_in  = dst_mac_ff;
      src_mac_in  = src_mac_ff;
      protocol_in = protocol_ff;
      src_ip_in   = src_ip_ff;
      dst_ip_in   = dst_ip_ff;
      src_port_in = src_port_ff;
      dst_port_in = dst_port_ff;
      if (count_ff < ehmf_pkg::DST_MAC_END) begin
         dst_mac_in = {dst_mac_ff[39:0], a_word_ff.data_byte};
      end else if (count_ff < ehmf_pkg::SRC_MAC_END) begin
         src_mac_in = {src_mac_ff[39:0], a_word_ff.data_byte};
      end else if (count_ff == ehmf_pkg::PROTOCOL_POS) begin
         protocol_in = a_word_ff.data_byte;
      end else if (count_ff >= ehmf_pkg::SRC_IP_START && count_ff < ehmf_pkg::DST_IP_START) begin
         src_ip_in = {src_ip_ff[23:0], a_word_ff.data_byte};
      end else if (count_ff >= ehmf_pkg::DST_IP_START
                   && count_ff < ehmf_pkg::SRC_PORT_START) begin
         dst_ip_in = {dst_ip_ff[23:0], a_word_ff.data_byte};
      end else if (count_ff >= ehmf_pkg::SRC_PORT_START
                   && count_ff < ehmf_pkg::DST_PORT_START) begin
         src_port_in = {src_port_ff[7:0], a_word_ff.data_byte};
      end else if (count_ff >= ehmf_pkg::DST_PORT_START && count_ff < ehmf_pkg::HEADER_END) begin
         dst_port_in = {dst_port_ff[7:0], a_word_ff.data_byte};
      end
      if (count_ff < 16'(MAX_FRAME)) begin
         count_in = count_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (a_fire && is_frame) begin
         count_ff <= a_word_ff.last ? 16'd0 : count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire && is_frame) begin
         dst_mac_ff  <= a_word_ff.last ? '0 : dst_mac_in;
         src_mac_ff  <= a_word_ff.last ? '0 : src_mac_in;
         protocol_ff <= a_word_ff.last ? '0 : protocol_in;
         src_ip_ff   <= a_word_ff.last ? '0 : src_ip_in;
         dst_ip_ff   <= a_word_ff.last ? '0 : dst_ip_in;
         src_port_ff <= a_word_ff.last ? '0 : src_port_in;
         dst_port_ff <= a_word_ff.last ? '0 : dst_port_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         unique case (a_word_ff.list_sel)
            ehmf_pkg::LIST_SRC_IP:   src_ip_table_ff[wr_idx]   <= a_word_ff.entry_value[31:0];
            ehmf_pkg::LIST_DST_IP:   dst_ip_table_ff[wr_idx]   <= a_word_ff.entry_value[31:0];
            ehmf_pkg::LIST_SRC_PORT: src_port_table_ff[wr_idx] <= a_word_ff.entry_value[15:0];
            ehmf_pkg::LIST_DST_PORT: dst_port_table_ff[wr_idx] <= a_word_ff.entry_value[15:0];
            ehmf_pkg::LIST_SRC_MAC:  src_mac_table_ff[wr_idx]  <= a_word_ff.entry_value;
            ehmf_pkg::LIST_DST_MAC:  dst_mac_table_ff[wr_idx]  <= a_word_ff.entry_value;
            ehmf_pkg::LIST_PROTOCOL: protocol_table_ff[wr_idx] <= a_word_ff.entry_value[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ehmf_pkg::LIST_COUNT; k++) begin
            slot_valid_ff[k] <= '0;
         end
      end else if (wr_en) begin
         for (int k = 0; k < ehmf_pkg::LIST_COUNT; k++) begin
            if (a_word_ff.list_sel == 3'(k)) begin
               slot_valid_ff[k][wr_idx] <= a_word_ff.entry_valid;
            end
         end
      end
   end

   // A frame that can pass is longer than the headers, so the captures are
   // complete before its last byte and the compare uses them directly.
   always_comb begin
      for (int i = 0; i < FILTER_ENTRIES; i++) begin
         hit_src_ip[i]   = slot_valid_ff[ehmf_pkg::LIST_SRC_IP][i]
                           && (src_ip_table_ff[i] == src_ip_ff);
         hit_dst_ip[i]   = slot_valid_ff[ehmf_pkg::LIST_DST_IP][i]
                           && (dst_ip_table_ff[i] == dst_ip_ff);
         hit_src_port[i] = slot_valid_ff[ehmf_pkg::LIST_SRC_PORT][i]
                           && (src_port_table_ff[i] == src_port_ff);
         hit_dst_port[i] = slot_valid_ff[ehmf_pkg::LIST_DST_PORT][i]
                           && (dst_port_table_ff[i] == dst_port_ff);
         hit_src_mac[i]  = slot_valid_ff[ehmf_pkg::LIST_SRC_MAC][i]
                           && (src_mac_table_ff[i] == src_mac_ff);
         hit_dst_mac[i]  = slot_valid_ff[ehmf_pkg::LIST_DST_MAC][i]
                           && (dst_mac_table_ff[i] == dst_mac_ff);
         hit_protocol[i] = slot_valid_ff[ehmf_pkg::LIST_PROTOCOL][i]
                           && (protocol_table_ff[i] == protocol_ff);
      end
   end

   assign list_pass[ehmf_pkg::LIST_SRC_IP] =
      (slot_valid_ff[ehmf_pkg::LIST_SRC_IP] == '0) || (|hit_src_ip);
   assign list_pass[ehmf_pkg::LIST_DST_IP] =
      (slot_valid_ff[ehmf_pkg::LIST_DST_IP] == '0) || (|hit_dst_ip);
   assign list_pass[ehmf_pkg::LIST_SRC_PORT] =
      (slot_valid_ff[ehmf_pkg::LIST_SRC_PORT] == '0) || (|hit_src_port);
   assign list_pass[ehmf_pkg::LIST_DST_PORT] =
      (slot_valid_ff[ehmf_pkg::LIST_DST_PORT] == '0) || (|hit_dst_port);
   assign list_pass[ehmf_pkg::LIST_SRC_MAC] =
      (slot_valid_ff[ehmf_pkg::LIST_SRC_MAC] == '0) || (|hit_src_mac);
   assign list_pass[ehmf_pkg::LIST_DST_MAC] =
      (slot_valid_ff[ehmf_pkg::LIST_DST_MAC] == '0) || (|hit_dst_mac);
   assign list_pass[ehmf_pkg::LIST_PROTOCOL] =
      (slot_valid_ff[ehmf_pkg::LIST_PROTOCOL] == '0) || (|hit_protocol);

   always_comb begin
      rsp_word_in.frame_length = count_in;
      priority if (count_in <= ehmf_pkg::SHORT_LIMIT) begin
         rsp_word_in.status = ehmf_pkg::STATUS_SHORT;
      end else if (&list_pass) begin
         rsp_word_in.status = ehmf_pkg::STATUS_ACCEPT;
      end else begin
         rsp_word_in.status = ehmf_pkg::STATUS_REJECT;
      end
      rsp_word_in.accept = rsp_word_in.status == ehmf_pkg::STATUS_ACCEPT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef NO_ASSERTIONS
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("response register loaded while a held word was not taken");

   a_accept_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.accept == (rsp_word_ff.status == ehmf_pkg::STATUS_ACCEPT)))
      else $error("accept flag disagrees with status");

   a_short_length : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_word_ff.status == ehmf_pkg::STATUS_SHORT)
      |-> rsp_word_ff.frame_length <= ehmf_pkg::SHORT_LIMIT)
      else $error("short status on a frame above the header length");

   a_count_cleared : assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> count_ff == 16'd0)
      else $error("byte count not cleared after the final byte");
`endif

endmodule
